>>> design/keyword_tokenizer_defines.svh
// ---------------------------------------------------------------------------
// keyword_tokenizer assertion macros
// Shared concurrent assertion shorthands for the tokenizer RTL.
// ---------------------------------------------------------------------------
`ifndef KEYWORD_TOKENIZER_DEFINES_SVH
`define KEYWORD_TOKENIZER_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define KT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define KT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/kt_pkg.sv
// ---------------------------------------------------------------------------
// kt_pkg
// Types, constants and the keyword table of the keyword tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package kt_pkg;

  localparam int unsigned LaDepth = 7;
  localparam int unsigned NumKw   = 40;

  typedef logic [2:0]                 kt_cnt_t;
  typedef logic [5:0]                 kt_idx_t;
  typedef logic [LaDepth-1:0][7:0]    kt_buf_t;

  // Keyword text is right-aligned: first character in the top used byte
  typedef struct packed {
    logic [55:0] txt;
    logic [2:0]  len;
    logic [7:0]  code;
  } kt_kw_t;

  // Result of comparing one table entry with the lookahead head
  typedef struct packed {
    logic       full;
    logic       partial;
    logic [2:0] len;
    logic [7:0] code;
  } kt_match_t;

  localparam kt_idx_t    KW_LAST = 6'd39;
  localparam logic [7:0] QUOTE   = 8'h22;

  localparam kt_kw_t KW_TABLE [NumKw] = '{
    '{56'(">="), 3'd2, 8'hA5}, '{56'("<="), 3'd2, 8'hA6},
    '{56'("<>"), 3'd2, 8'hA4}, '{56'("!="), 3'd2, 8'hA4},
    '{56'("=="), 3'd2, 8'hA3}, '{56'("PRINT"), 3'd5, 8'h80},
    '{56'("LET"), 3'd3, 8'h81}, '{56'("GOTO"), 3'd4, 8'h82},
    '{56'("IF"), 3'd2, 8'h83}, '{56'("THEN"), 3'd4, 8'h84},
    '{56'("INPUT"), 3'd5, 8'h85}, '{56'("END"), 3'd3, 8'h86},
    '{56'("LIST"), 3'd4, 8'h87}, '{56'("RUN"), 3'd3, 8'h88},
    '{56'("CLEAR"), 3'd5, 8'h89}, '{56'("FOR"), 3'd3, 8'h8A},
    '{56'("TO"), 3'd2, 8'h8B}, '{56'("NEXT"), 3'd4, 8'h8C},
    '{56'("STEP"), 3'd4, 8'h8D}, '{56'("GOSUB"), 3'd5, 8'h8E},
    '{56'("RETURN"), 3'd6, 8'h8F}, '{56'("DIM"), 3'd3, 8'h90},
    '{56'("DATA"), 3'd4, 8'h91}, '{56'("READ"), 3'd4, 8'h92},
    '{56'("RESTORE"), 3'd7, 8'h93}, '{56'("POKE"), 3'd4, 8'h94},
    '{56'("PEEK"), 3'd4, 8'h95}, '{56'("RND"), 3'd3, 8'h96},
    '{56'("ABS"), 3'd3, 8'h97}, '{56'("SGN"), 3'd3, 8'h98},
    '{56'("CLAMP"), 3'd5, 8'h99}, '{56'("BITREAD"), 3'd7, 8'h9B},
    '{56'("BITSET"), 3'd6, 8'h9C}, '{56'("BITCLR"), 3'd6, 8'h9D},
    '{56'("BIT"), 3'd3, 8'h9A}, '{56'("LEN"), 3'd3, 8'h9E},
    '{56'("VAL"), 3'd3, 8'h9F}, '{56'("STR$"), 3'd4, 8'hA0},
    '{56'("LEFT$"), 3'd5, 8'hA1}, '{56'("RIGHT$"), 3'd6, 8'hA2}
  };

  // Fold lower-case letters onto upper case
  function automatic logic [7:0] upcase(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/kt_stream_if.sv
// ---------------------------------------------------------------------------
// kt_in_if / kt_out_if
// Valid/ready channels carrying source bytes in and tokenized bytes out.
// ---------------------------------------------------------------------------
`default_nettype none

interface kt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface kt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       last_byte;

  modport source (output valid, output byte_out, output last_byte, input ready);
  modport sink   (input valid, input byte_out, input last_byte, output ready);
endinterface

`default_nettype wire

>>> design/kt_matcher.sv
// ---------------------------------------------------------------------------
// kt_matcher
// Shared compare unit: one keyword table entry against the lookahead head.
// ---------------------------------------------------------------------------
`default_nettype none

module kt_matcher (
  input  wire kt_pkg::kt_buf_t   buf_i,
  input  wire kt_pkg::kt_cnt_t   count_i,
  input  wire kt_pkg::kt_idx_t   entry_i,
  output kt_pkg::kt_match_t      res_o
);
  import kt_pkg::*;

  kt_kw_t kw;
  logic   ok;
  int     sh;

  assign kw = KW_TABLE[entry_i];

  // Compare the pending bytes that overlap the keyword, case-folded
  always_comb begin
    ok = 1'b1;
    sh = 0;
    for (int j = 0; j < LaDepth; j++) begin
      if (j < int'(kw.len) && j < int'(count_i)) begin
        sh = int'(kw.len) - 1 - j;
        if (upcase(buf_i[j]) != kw.txt[8*sh +: 8]) begin
          ok = 1'b0;
        end
      end
    end
  end

  assign res_o.full    = ok && (count_i >= kw.len);
  assign res_o.partial = ok && (count_i < kw.len);
  assign res_o.len     = kw.len;
  assign res_o.code    = kw.code;

endmodule

`default_nettype wire

>>> design/keyword_tokenizer.sv
// A quoted or raw-quote byte resolves without a table lookup; a table lookup
// walks the 40 keyword entries one per cycle until a match, a partial match before
// the last beat or the last entry; a resolved byte waits while output is stalled.
// Throughput: one input beat per scan; input is held off until pending text
// is resolved as far as possible. Output is registered.
// Reset: lookahead count, quote flag, last-beat flag, sequencer and output valid clear.
// ---------------------------------------------------------------------------
// keyword_tokenizer
// Streaming keyword tokenizer with a seven-byte lookahead and one compare unit.
// ---------------------------------------------------------------------------
`default_nettype none

`include "keyword_tokenizer_defines.svh"

module keyword_tokenizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kt_in_if.sink     in_i,
  kt_out_if.source  out_o
);
  import kt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } kt_state_e;

  kt_state_e  state_q, state_d;
  kt_buf_t    buf_q, buf_d;
  kt_cnt_t    count_q, count_d;
  kt_idx_t    entry_q, entry_d;
  logic       quote_q, quote_d;
  logic       final_q, final_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q, obyte_d;
  logic       olast_q, olast_d;

  kt_match_t  match;
  logic       in_fire, out_free;
  logic       emit;
  logic [7:0] emit_byte;
  logic [2:0] emit_len;
  kt_cnt_t    rest;

  kt_matcher u_matcher (
    .buf_i   (buf_q),
    .count_i (count_q),
    .entry_i (entry_q),
    .res_o   (match)
  );

  assign in_i.ready      = (state_q == S_IDLE);
  assign in_fire         = in_i.valid && in_i.ready;
  assign out_free        = !ovalid_q || out_o.ready;
  assign out_o.valid     = ovalid_q;
  assign out_o.byte_out  = obyte_q;
  assign out_o.last_byte = olast_q;
  assign rest            = count_q - emit_len;

  // Sequencer: append a beat, then resolve the head one table entry a cycle
  always_comb begin
    state_d   = state_q;
    buf_d     = buf_q;
    count_d   = count_q;
    entry_d   = entry_q;
    quote_d   = quote_q;
    final_d   = final_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    obyte_d   = obyte_q;
    olast_d   = olast_q;
    emit      = 1'b0;
    emit_byte = buf_q[0];
    emit_len  = 3'd1;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          buf_d[count_q] = in_i.char_in;
          count_d        = count_q + 3'd1;
          final_d        = in_i.last_char;
          entry_d        = '0;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (quote_q || buf_q[0] == QUOTE) begin
          emit = 1'b1;
        end else if (match.full) begin
          emit      = 1'b1;
          emit_byte = match.code;
          emit_len  = match.len;
        end else if (match.partial && !final_q) begin
          // the current entry still needs more text
          state_d = S_IDLE;
        end else if (entry_q == KW_LAST) begin
          emit = 1'b1;
        end else begin
          entry_d = entry_q + 6'd1;
        end

        if (emit && out_free) begin
          ovalid_d = 1'b1;
          obyte_d  = emit_byte;
          olast_d  = final_q && (rest == '0);
          if (buf_q[0] == QUOTE) begin
            quote_d = !quote_q;
          end
          buf_d   = kt_buf_t'(buf_q >> {emit_len, 3'b000});
          count_d = rest;
          entry_d = '0;
          if (rest == '0) begin
            state_d = S_IDLE;
            if (final_q) begin
              quote_d = 1'b0;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      entry_q  <= '0;
      quote_q  <= 1'b0;
      final_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      entry_q  <= entry_d;
      quote_q  <= quote_d;
      final_q  <= final_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    buf_q   <= buf_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  `KT_ASSERT_IMP(a_scan_nonempty, state_q == S_SCAN, count_q != '0, "scan with empty lookahead")
  `KT_ASSERT_IMP(a_idle_room, state_q == S_IDLE, count_q <= 3'd6, "lookahead full when idle")
  `KT_ASSERT(a_entry_range, entry_q <= KW_LAST, "table index out of range")
  `KT_ASSERT_IMP(a_last_empties, ovalid_d && !ovalid_q && olast_d, ##1 count_q == '0,
                 "last beat with text pending")

endmodule

`default_nettype wire
